@@ rtl/kvst_pkg.sv @@
// kvst_pkg: shared types, codes and helpers for the key/value slot table
`default_nettype none
package kvst_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;

  // command codes
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADLEN   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_OVERCAP  = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [3:0]  key_length;
    logic [63:0] value;
    logic [3:0]  value_length;
    logic [3:0]  capacity;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [3:0]  read_value_length;
    logic [63:0] match_key;
    logic [3:0]  match_key_length;
    logic [4:0]  match_count;
    logic        last;
  } res_t;

  // command token handed from cell to cell
  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [3:0]  key_length;
    logic [63:0] value;
    logic [3:0]  value_length;
    logic [3:0]  capacity;
    logic        done;
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [3:0]  read_value_length;
    logic [4:0]  match_count;
  } tok_t;

  // ones over the low n bytes, all ones from eight bytes up
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/kvst_cell.sv @@
// kvst_cell: one slot of the table plus the token register that visits it
`default_nettype none
module kvst_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          out_free,
  input  wire logic          tok_in_valid,
  input  wire kvst_pkg::tok_t tok_in,
  output logic               tok_out_valid,
  output kvst_pkg::tok_t     tok_out,
  output logic               busy,
  output logic               emit,
  output kvst_pkg::res_t     emit_res
);
  import kvst_pkg::*;

  tok_t        cur;
  logic        cur_valid;
  logic        slot_valid;
  logic [63:0] slot_key;
  logic [3:0]  slot_key_length;
  logic [63:0] slot_value;
  logic [3:0]  slot_value_length;

  logic exact, prefix, emit_want, go, write_hit, write_new;

  always_comb begin
    exact  = slot_valid && (slot_key_length == cur.key_length) && (slot_key == cur.key);
    prefix = slot_valid && ((cur.key_length == 4'd0) ||
             ((slot_key_length >= cur.key_length) &&
              ((slot_key & byte_mask(cur.key_length)) == cur.key)));
    emit_want = cur_valid && (cur.command == CMD_LIST) && prefix;
    go        = cur_valid && (!emit_want || out_free);

    tok_out   = cur;
    write_hit = 1'b0;
    write_new = 1'b0;
    case (cur.command)
      CMD_PUT: begin
        if (!cur.done) begin
          if (exact) begin
            write_hit      = go;
            tok_out.done   = 1'b1;
            tok_out.status = ST_OK;
          end else if (!slot_valid) begin
            // slots fill from the bottom, so the first free one ends the search
            write_new      = go;
            tok_out.done   = 1'b1;
            tok_out.status = ST_OK;
          end
        end
      end
      CMD_GET: begin
        if (!cur.done && exact) begin
          tok_out.done = 1'b1;
          if (slot_value_length > cur.capacity) begin
            tok_out.status = ST_OVERCAP;
          end else begin
            tok_out.status            = ST_OK;
            tok_out.read_value        = slot_value;
            tok_out.read_value_length = slot_value_length;
          end
        end
      end
      CMD_LIST: begin
        if (prefix) begin
          tok_out.match_count = cur.match_count + 5'd1;
        end
      end
      default: begin
      end
    endcase

    tok_out_valid = go;
    busy          = cur_valid;
    emit          = emit_want && out_free;
    emit_res      = '0;
    if (emit) begin
      emit_res.status            = ST_OK;
      emit_res.read_value        = slot_value;
      emit_res.read_value_length = slot_value_length;
      emit_res.match_key         = slot_key;
      emit_res.match_key_length  = slot_key_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      slot_valid <= 1'b0;
    end else begin
      if (tok_in_valid) begin
        cur_valid <= 1'b1;
      end else if (go) begin
        cur_valid <= 1'b0;
      end
      if (write_new) begin
        slot_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      cur <= tok_in;
    end
    if (write_hit || write_new) begin
      slot_value        <= cur.value;
      slot_value_length <= cur.value_length;
    end
    if (write_new) begin
      slot_key        <= cur.key;
      slot_key_length <= cur.key_length;
    end
  end

endmodule
`default_nettype wire

@@ rtl/key_value_slot_table.sv @@
// key_value_slot_table: top level, a chain of slot cells with a tail stage and result register
//
//  channel   direction  payload            transfer when
//  request   in         kvst_pkg::req_t    request_valid && request_ready
//  result    out        kvst_pkg::res_t    result_valid && result_ready
//
// a command token enters cell 0 and steps one cell per cycle unless a list emit stalls it, then lands in the tail
// the next request is taken once the closing result has left the tail; during a list a
// matching cell holds the token while it finds the result register still full, and the
// token is not held while the output drains
// reset clears every slot valid bit and every token valid flag; slot data is never cleared
// a stalled result register freezes the token at the cell that wants to emit
`default_nettype none
module key_value_slot_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           request_valid,
  output logic                request_ready,
  input  wire kvst_pkg::req_t request,
  output logic                result_valid,
  input  wire logic           result_ready,
  output kvst_pkg::res_t      result
);
  import kvst_pkg::*;

  // one command in flight at a time
  logic busy;
  logic accept;

  tok_t tok0;

  logic [ENTRIES-1:0] chain_valid;
  tok_t               chain_tok [ENTRIES];
  logic [ENTRIES-1:0] cell_busy;
  logic [ENTRIES-1:0] cell_emit;
  res_t               cell_res  [ENTRIES];

  // tail stage: the token after the last cell
  logic tail_valid;
  tok_t tail;
  logic tail_fire;
  res_t tail_res;

  logic out_free;
  logic out_load;
  res_t emit_or;

  assign request_ready = !busy;
  assign accept        = request_valid && request_ready;
  assign out_free      = !result_valid || result_ready;

  // build the token, masking bytes beyond the given lengths
  always_comb begin
    tok0.command           = request.command;
    tok0.key               = request.key & byte_mask(request.key_length);
    tok0.key_length        = request.key_length;
    tok0.value             = request.value & byte_mask(request.value_length);
    tok0.value_length      = request.value_length;
    tok0.capacity          = request.capacity;
    tok0.done              = 1'b0;
    tok0.status            = ST_OK;
    tok0.read_value        = '0;
    tok0.read_value_length = '0;
    tok0.match_count       = '0;
    case (request.command)
      CMD_PUT: begin
        // bad lengths settle the put before it reaches any slot
        if ((request.key_length == 4'd0) || (request.key_length > 4'(KEY_BYTES)) ||
            (request.value_length > 4'(VALUE_BYTES))) begin
          tok0.done   = 1'b1;
          tok0.status = ST_BADLEN;
        end
      end
      CMD_GET, CMD_LIST: begin
      end
      default: begin
        // unknown command passes through untouched, reported as bad length
        tok0.done   = 1'b1;
        tok0.status = ST_BADLEN;
      end
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      kvst_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .out_free     (out_free),
        .tok_in_valid (accept),
        .tok_in       (tok0),
        .tok_out_valid(chain_valid[i]),
        .tok_out      (chain_tok[i]),
        .busy         (cell_busy[i]),
        .emit         (cell_emit[i]),
        .emit_res     (cell_res[i])
      );
    end else begin : g_body
      kvst_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .out_free     (out_free),
        .tok_in_valid (chain_valid[i-1]),
        .tok_in       (chain_tok[i-1]),
        .tok_out_valid(chain_valid[i]),
        .tok_out      (chain_tok[i]),
        .busy         (cell_busy[i]),
        .emit         (cell_emit[i]),
        .emit_res     (cell_res[i])
      );
    end
  end

  // at most one cell emits in a cycle; unused cells drive zero
  always_comb begin
    emit_or = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      emit_or = emit_or | cell_res[i];
    end
  end

  // closing result for every command
  always_comb begin
    tail_fire                  = tail_valid && out_free;
    tail_res                   = '0;
    tail_res.last              = 1'b1;
    tail_res.status            = tail.status;
    tail_res.read_value        = tail.read_value;
    tail_res.read_value_length = tail.read_value_length;
    case (tail.command)
      CMD_PUT: begin
        if (!tail.done) begin
          tail_res.status = ST_FULL;
        end
      end
      CMD_GET: begin
        if (!tail.done) begin
          tail_res.status = ST_NOTFOUND;
        end
      end
      CMD_LIST: begin
        tail_res.status      = ST_OK;
        tail_res.match_count = tail.match_count;
      end
      default: begin
      end
    endcase
  end

  assign out_load = tail_fire || (|cell_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      tail_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail_fire) begin
        busy <= 1'b0;
      end
      if (chain_valid[ENTRIES-1]) begin
        tail_valid <= 1'b1;
      end else if (tail_fire) begin
        tail_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[ENTRIES-1]) begin
      tail <= chain_tok[ENTRIES-1];
    end
    if (out_load) begin
      result <= tail_fire ? tail_res : emit_or;
    end
  end

  // exactly one token lives in the chain or tail while a command is in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot({tail_valid, cell_busy}))
    else $error("token count wrong while busy");

  a_no_token_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ({tail_valid, cell_busy} == '0))
    else $error("stray token while idle");

  // cell emission and closing result never collide
  a_single_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tail_fire, cell_emit}))
    else $error("two result sources at once");

  // closing result frees the block for the next request
  a_close_frees: assert property (@(posedge clk) disable iff (rst)
    tail_fire |=> (request_ready && result_valid && result.last))
    else $error("closing transfer did not free the block");

endmodule
`default_nettype wire
